// ===== hw/rtl/brs_pkg.sv =====
// Shared constants and helpers for the bilinear resize sampler.
// No dependencies; used by every module of the block.
package brs_pkg;

  localparam int unsigned MAX_SRC_WIDTH  = 256;
  localparam int unsigned MAX_SRC_HEIGHT = 256;
  localparam int unsigned FRAC_BITS      = 12;

  localparam int unsigned CoordW  = 12;                 // row / col width
  localparam int unsigned SrcRegW = 9;                  // source size registers
  localparam int unsigned DstRegW = 13;                 // dest size registers
  localparam int unsigned ChanW   = 8;
  localparam int unsigned PixW    = 3 * ChanW;
  localparam int unsigned NumW    = 2 * CoordW;         // idx * (src-1)
  localparam int unsigned QuoW    = NumW + FRAC_BITS;   // quotient with fraction
  localparam int unsigned WgtW    = FRAC_BITS + 1;      // weight 0..1.0
  localparam int unsigned AddrW   = $clog2(MAX_SRC_WIDTH * MAX_SRC_HEIGHT);
  localparam int unsigned XW      = $clog2(MAX_SRC_WIDTH);
  localparam int unsigned YW      = $clog2(MAX_SRC_HEIGHT);

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_BLEND,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [AddrW-1:0] addr;
  } store_ctl_t;

  function automatic logic [AddrW-1:0] pix_addr(input logic [YW-1:0] y,
                                                input logic [XW-1:0] x);
    logic [AddrW-1:0] a;
    a = AddrW'(AddrW'(y) * AddrW'(MAX_SRC_WIDTH) + AddrW'(x));
    return a;
  endfunction

  function automatic logic [DstRegW-1:0] clamp_size(input logic [SrcRegW-1:0] v,
                                                    input int unsigned maxv);
    logic [DstRegW-1:0] r;
    if (v == '0) r = DstRegW'(1);
    else if (DstRegW'(v) > DstRegW'(maxv)) r = DstRegW'(maxv);
    else r = DstRegW'(v);
    return r;
  endfunction

endpackage

// ===== hw/rtl/brs_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on brs_pkg.
module brs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [brs_pkg::NumW-1:0]    num_i,
  input  logic [brs_pkg::DstRegW-1:0] den_i,
  output logic                        done_o,
  output logic [brs_pkg::QuoW-1:0]    quo_o
);

  localparam int unsigned CntW = $clog2(brs_pkg::QuoW + 1);

  logic [brs_pkg::QuoW-1:0]    dvd_q, dvd_d;
  logic [brs_pkg::DstRegW-1:0] rem_q, rem_d, den_q;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        run_q, run_d, done_q, done_d;
  logic [brs_pkg::DstRegW:0]   trial;
  logic                        qbit;

  always_comb begin
    trial = {rem_q, dvd_q[brs_pkg::QuoW-1]};
    qbit  = (trial >= {1'b0, den_q});
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = {num_i, {brs_pkg::FRAC_BITS{1'b0}}};
      rem_d = '0;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      dvd_d = {dvd_q[brs_pkg::QuoW-2:0], qbit};
      rem_d = qbit ? brs_pkg::DstRegW'(trial - {1'b0, den_q})
                   : trial[brs_pkg::DstRegW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(brs_pkg::QuoW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = dvd_q;

endmodule

// ===== hw/rtl/brs_lane.sv =====
// One channel lane of the bilinear blend: horizontal, vertical, round.
// Three register stages, no stall. Depends on brs_pkg.
module brs_lane (
  input  logic                          clk_i,
  input  logic [brs_pkg::ChanW-1:0]     p00_i,
  input  logic [brs_pkg::ChanW-1:0]     p01_i,
  input  logic [brs_pkg::ChanW-1:0]     p10_i,
  input  logic [brs_pkg::ChanW-1:0]     p11_i,
  input  logic [brs_pkg::FRAC_BITS-1:0] fx_i,
  input  logic [brs_pkg::FRAC_BITS-1:0] fy_i,
  output logic [brs_pkg::ChanW-1:0]     chan_o
);

  localparam int unsigned HW   = brs_pkg::ChanW + brs_pkg::WgtW;
  localparam int unsigned AccW = HW + brs_pkg::WgtW;
  localparam int unsigned RndW = AccW + 1;

  logic [brs_pkg::WgtW-1:0] one, wx0, wx1, wy0, wy1;
  logic [HW-1:0]            top_q, bot_q;
  logic [AccW-1:0]          acc_q;
  logic [RndW-1:0]          rnd;
  logic [RndW-1:0]          shr;
  logic [brs_pkg::ChanW-1:0] chan_q;

  always_comb begin
    one = brs_pkg::WgtW'(1) << brs_pkg::FRAC_BITS;
    wx1 = brs_pkg::WgtW'(fx_i);
    wx0 = one - wx1;
    wy1 = brs_pkg::WgtW'(fy_i);
    wy0 = one - wy1;
    rnd = RndW'(acc_q) + (RndW'(1) << (2 * brs_pkg::FRAC_BITS - 1));
    shr = rnd >> (2 * brs_pkg::FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    top_q  <= HW'(HW'(p00_i) * HW'(wx0) + HW'(p01_i) * HW'(wx1));
    bot_q  <= HW'(HW'(p10_i) * HW'(wx0) + HW'(p11_i) * HW'(wx1));
    acc_q  <= AccW'(AccW'(top_q) * AccW'(wy0) + AccW'(bot_q) * AccW'(wy1));
    chan_q <= (shr > RndW'(255)) ? brs_pkg::ChanW'(255) : shr[brs_pkg::ChanW-1:0];
  end

  assign chan_o = chan_q;

endmodule

// ===== hw/rtl/brs_store.sv =====
// Single-port frame store, registered read data.
// Depends on brs_pkg.
module brs_store (
  input  logic                      clk_i,
  input  brs_pkg::store_ctl_t       ctl_i,
  input  logic [brs_pkg::PixW-1:0]  wdata_i,
  output logic [brs_pkg::PixW-1:0]  rdata_o
);

  logic [brs_pkg::PixW-1:0] mem [brs_pkg::MAX_SRC_WIDTH * brs_pkg::MAX_SRC_HEIGHT];
  logic [brs_pkg::PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) mem[ctl_i.addr] <= wdata_i;
    if (ctl_i.re) rdata_q <= mem[ctl_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bilinear_resize_sampler_core.sv =====
// Bilinear resampler (align corners) over a 256x256x24-bit frame store.
// A pixel write is accepted every cycle while the core is idle. A request in
// range passes through the bit-serial position dividers (both axes in
// parallel, 36 quotient bits plus handoff), the four neighbor reads from the
// single-port store, the blend lanes and the output load. An out-of-range
// request goes straight to the output stage. The next request is taken in the
// cycle after the result is loaded; a stalled receiver holds a finished
// request in the output stage.
// Depends on brs_pkg, brs_div, brs_lane, brs_store.
module bilinear_resize_sampler_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [47:0]                 s_axis_tdata_i,  // row, col, in_chan0..2
  input  logic                        s_axis_tuser_i,  // mode
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [23:0]                 m_axis_tdata_o,  // out_chan0..2
  output logic                        m_axis_tuser_o,  // out_of_range
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [brs_pkg::DstRegW-1:0] cfg_data_i
);

  localparam int unsigned CW = brs_pkg::CoordW;
  localparam int unsigned FB = brs_pkg::FRAC_BITS;

  brs_pkg::state_e state_q, state_d;

  logic [brs_pkg::SrcRegW-1:0] src_w_q, src_h_q;
  logic [brs_pkg::DstRegW-1:0] dst_w_q, dst_h_q;
  logic [brs_pkg::DstRegW-1:0] sw, sh;
  logic [CW-1:0]               swm1, shm1;
  logic [brs_pkg::DstRegW-1:0] dwm1, dhm1;

  logic [CW-1:0] in_row, in_col;
  logic          in_mode, accept, req_ok, wr_ok;

  logic          dw1_q, dh1_q;
  logic          xdone, ydone;
  logic [brs_pkg::QuoW-1:0] xquo, yquo;
  logic [CW-1:0] x0, y0;
  logic [FB-1:0] fx, fy;
  logic [CW-1:0] x0_q, x1_q, y0_q, y1_q;
  logic [FB-1:0] fx_q, fy_q;

  logic [2:0]    cnt_q, cnt_d;
  logic [brs_pkg::PixW-1:0] pix_q [4];
  logic [brs_pkg::PixW-1:0] rdata;
  brs_pkg::store_ctl_t      sctl;
  logic [CW-1:0] rx, ry;

  logic [brs_pkg::ChanW-1:0] lane_out [3];
  logic          oor_q, out_load;
  logic          mvalid_q;
  logic [23:0]   mdata_q;
  logic          muser_q;

  assign in_mode = s_axis_tuser_i;
  assign in_row  = s_axis_tdata_i[11:0];
  assign in_col  = s_axis_tdata_i[23:12];
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    sw   = brs_pkg::clamp_size(src_w_q, brs_pkg::MAX_SRC_WIDTH);
    sh   = brs_pkg::clamp_size(src_h_q, brs_pkg::MAX_SRC_HEIGHT);
    swm1 = CW'(sw - 1'b1);
    shm1 = CW'(sh - 1'b1);
    dwm1 = dst_w_q - 1'b1;
    dhm1 = dst_h_q - 1'b1;
    req_ok = (brs_pkg::DstRegW'(in_row) < dst_h_q) && (brs_pkg::DstRegW'(in_col) < dst_w_q);
    wr_ok  = (brs_pkg::DstRegW'(in_row) < sh) && (brs_pkg::DstRegW'(in_col) < sw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= brs_pkg::SrcRegW'(256);
      src_h_q <= brs_pkg::SrcRegW'(256);
      dst_w_q <= brs_pkg::DstRegW'(256);
      dst_h_q <= brs_pkg::DstRegW'(256);
    end else if (cfg_we_i) begin
      unique case (brs_pkg::reg_idx_e'(cfg_idx_i))
        brs_pkg::REG_SRC_WIDTH:  src_w_q <= cfg_data_i[brs_pkg::SrcRegW-1:0];
        brs_pkg::REG_SRC_HEIGHT: src_h_q <= cfg_data_i[brs_pkg::SrcRegW-1:0];
        brs_pkg::REG_DST_WIDTH:  dst_w_q <= cfg_data_i;
        brs_pkg::REG_DST_HEIGHT: dst_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  brs_div u_div_x (
    .clk_i, .rst_ni,
    .start_i (accept && in_mode && req_ok),
    .num_i   (brs_pkg::NumW'(brs_pkg::NumW'(in_col) * brs_pkg::NumW'(swm1))),
    .den_i   (dwm1),
    .done_o  (xdone),
    .quo_o   (xquo)
  );

  brs_div u_div_y (
    .clk_i, .rst_ni,
    .start_i (accept && in_mode && req_ok),
    .num_i   (brs_pkg::NumW'(brs_pkg::NumW'(in_row) * brs_pkg::NumW'(shm1))),
    .den_i   (dhm1),
    .done_o  (ydone),
    .quo_o   (yquo)
  );

  always_comb begin
    if (dw1_q) begin
      x0 = '0; fx = '0;
    end else if (xquo[brs_pkg::QuoW-1:FB] > brs_pkg::NumW'(swm1)) begin
      x0 = swm1; fx = '0;
    end else begin
      x0 = xquo[FB +: CW]; fx = xquo[FB-1:0];
    end
    if (dh1_q) begin
      y0 = '0; fy = '0;
    end else if (yquo[brs_pkg::QuoW-1:FB] > brs_pkg::NumW'(shm1)) begin
      y0 = shm1; fy = '0;
    end else begin
      y0 = yquo[FB +: CW]; fy = yquo[FB-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      brs_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (accept && in_mode) state_d = req_ok ? brs_pkg::ST_DIV : brs_pkg::ST_OUT;
      end
      brs_pkg::ST_DIV:   if (xdone && ydone) state_d = brs_pkg::ST_READ;
      brs_pkg::ST_READ: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 3'd4) begin
          cnt_d   = '0;
          state_d = brs_pkg::ST_BLEND;
        end
      end
      brs_pkg::ST_BLEND: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 3'd2) state_d = brs_pkg::ST_OUT;
      end
      brs_pkg::ST_OUT:   if (out_load) state_d = brs_pkg::ST_IDLE;
      default:           state_d = brs_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready_o = (state_q == brs_pkg::ST_IDLE);
    out_load = (state_q == brs_pkg::ST_OUT) && (!mvalid_q || m_axis_tready_i);
    unique case (cnt_q[1:0])
      2'd0:    begin rx = x0_q; ry = y0_q; end
      2'd1:    begin rx = x1_q; ry = y0_q; end
      2'd2:    begin rx = x0_q; ry = y1_q; end
      default: begin rx = x1_q; ry = y1_q; end
    endcase
    sctl.we = accept && !in_mode && wr_ok;
    sctl.re = (state_q == brs_pkg::ST_READ) && (cnt_q != 3'd4);
    sctl.addr = sctl.we ? brs_pkg::pix_addr(in_row[brs_pkg::YW-1:0], in_col[brs_pkg::XW-1:0])
                        : brs_pkg::pix_addr(ry[brs_pkg::YW-1:0], rx[brs_pkg::XW-1:0]);
  end

  brs_store u_store (
    .clk_i,
    .ctl_i   (sctl),
    .wdata_i (s_axis_tdata_i[47:24]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= brs_pkg::ST_IDLE;
      cnt_q    <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) mvalid_q <= 1'b1;
      else if (m_axis_tready_i) mvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      oor_q <= !req_ok;
      dw1_q <= (dst_w_q <= brs_pkg::DstRegW'(1));
      dh1_q <= (dst_h_q <= brs_pkg::DstRegW'(1));
    end
    if (state_q == brs_pkg::ST_DIV) begin
      x0_q <= x0;
      y0_q <= y0;
      x1_q <= (x0 < swm1) ? x0 + 1'b1 : swm1;
      y1_q <= (y0 < shm1) ? y0 + 1'b1 : shm1;
      fx_q <= fx;
      fy_q <= fy;
    end
    if (state_q == brs_pkg::ST_READ && cnt_q != 3'd0) pix_q[cnt_q[1:0] - 2'd1] <= rdata;
    if (out_load) begin
      muser_q <= oor_q;
      mdata_q <= oor_q ? 24'd0 : {lane_out[2], lane_out[1], lane_out[0]};
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    brs_lane u_lane (
      .clk_i,
      .p00_i  (pix_q[0][k*brs_pkg::ChanW +: brs_pkg::ChanW]),
      .p01_i  (pix_q[1][k*brs_pkg::ChanW +: brs_pkg::ChanW]),
      .p10_i  (pix_q[2][k*brs_pkg::ChanW +: brs_pkg::ChanW]),
      .p11_i  (pix_q[3][k*brs_pkg::ChanW +: brs_pkg::ChanW]),
      .fx_i   (fx_q),
      .fy_i   (fy_q),
      .chan_o (lane_out[k])
    );
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = mdata_q;
  assign m_axis_tuser_o  = muser_q;

endmodule
